// ===== sv/sgoc_pkg.sv =====
// Shared types and constants for the segment grid overlap counter.
// No dependencies; every other file of the block but sgoc_ram imports this package.
package sgoc_pkg;

    localparam int CoordW        = 10;
    localparam int SizeW         = 11;
    localparam int CountW        = 21;
    localparam int StatusW       = 2;
    localparam int HitW          = 2;
    localparam int CfgIdxW       = 2;
    localparam int GridDimDefault = 1024;

    localparam logic [HitW-1:0]   HitSat    = HitW'(2);
    localparam logic [CountW-1:0] CountMax  = '1;
    localparam logic [SizeW-1:0]  SizeReset = SizeW'(1024);

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DIAG = 2'd0,
        CFG_COLS = 2'd1,
        CFG_ROWS = 2'd2
    } t_cfg_idx;

    // per-segment status code
    typedef enum logic [StatusW-1:0] {
        ST_DRAWN       = 2'd0,
        ST_DIAG_OFF    = 2'd1,
        ST_SLANTED     = 2'd2,
        ST_OUT_OF_GRID = 2'd3
    } t_seg_status;

    typedef struct packed {
        logic load;     // capture endpoints of a new item
        logic check;    // classify segment, set step count
        logic draw;     // issue read for one cell, step to next
        logic clear;    // write zero at sweep address, advance sweep
    } t_dp_cmd;

    typedef struct packed {
        logic drawable;    // classification says draw
        logic last_cell;   // current cell is the segment's last
        logic clear_last;  // sweep is at the final address
    } t_dp_stat;

endpackage

// ===== sv/segment_grid_overlap_counter.sv =====
// Top level of the segment grid overlap counter.
// Depends on sgoc_pkg, sgoc_ctrl, sgoc_dp (which holds the sgoc_ram hit store).
//
// Usage:
//   Input: a segment item (i_start_x/y, i_end_x/y) is taken at a clock edge
//   where start is high and busy is low. busy stays high until the result
//   has been shown.
//   Output: o_strobe is high for one cycle with o_overlap_cells (running count
//   of cells hit two or more times) and o_segment_status. The receiver cannot
//   stall; the result is valid in that cycle only.
//   Config: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data. Ready is
//   always high; writes take effect at once and belong between items.
//   Index 0 diag_enable, 1 grid_cols, 2 grid_rows; index 3 is ignored.
// Sequence:
//   After accept the item passes the classify state, then the draw state,
//   which steps through the cells with one read-modify-write per cell on the
//   hit store's single read and write port, then a write-back state and the
//   report state. busy drops in the cycle after the report; a new item is
//   taken only once busy is low. An ignored segment goes from classify
//   straight to the report state.
// Reset:
//   Synchronous, active low. After reset the hit store is swept to zero, one
//   cell per cycle, over all 2^(2*clog2(GRID_DIM)) cells (1,048,576 at the default
//   GRID_DIM); busy is high throughout. Config writes are accepted meanwhile.
module segment_grid_overlap_counter #(
    parameter int GRID_DIM = sgoc_pkg::GridDimDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sgoc_pkg::CoordW-1:0]   i_start_x,
    input  logic [sgoc_pkg::CoordW-1:0]   i_start_y,
    input  logic [sgoc_pkg::CoordW-1:0]   i_end_x,
    input  logic [sgoc_pkg::CoordW-1:0]   i_end_y,
    output logic                          o_strobe,
    output logic [sgoc_pkg::CountW-1:0]   o_overlap_cells,
    output logic [sgoc_pkg::StatusW-1:0]  o_segment_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sgoc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [sgoc_pkg::SizeW-1:0]    i_cfg_data
);
    import sgoc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // config is always taken; no internal conflict with item processing
    assign o_cfg_ready = 1'b1;

    sgoc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    sgoc_dp #(
        .GRID_DIM (GRID_DIM)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_overlap_cells  (o_overlap_cells),
        .o_segment_status (o_segment_status)
    );

    // accepted item keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accept");

    // a result is reported only while an item is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("strobe outside item processing");

    // one strobe per item: never two in a row
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    // overlap count only grows between resets
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_overlap_cells >= $past(o_overlap_cells)))
        else $error("overlap count decreased");

endmodule

// ===== sv/sgoc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module sgoc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sgoc_ctrl.sv =====
// Sequencer for the overlap counter: clear sweep, classify, draw, report.
// Depends on sgoc_pkg for the command and status structs.
module sgoc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sgoc_pkg::t_dp_stat i_stat,
    output sgoc_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_strobe
);
    import sgoc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_DRAW  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.drawable ? S_DRAW : S_DONE;
            end
            S_DRAW: begin
                o_cmd.draw = 1'b1;
                if (i_stat.last_cell) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;   // final write-back
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

endmodule

// ===== sv/sgoc_dp.sv =====
// Datapath: config registers, segment classifier, cell stepper, hit store
// read-modify-write and overlap count. Uses sgoc_pkg and sgoc_ram.
module sgoc_dp #(
    parameter int GRID_DIM = sgoc_pkg::GridDimDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sgoc_pkg::t_dp_cmd             i_cmd,
    output sgoc_pkg::t_dp_stat            o_stat,
    input  logic [sgoc_pkg::CoordW-1:0]   i_start_x,
    input  logic [sgoc_pkg::CoordW-1:0]   i_start_y,
    input  logic [sgoc_pkg::CoordW-1:0]   i_end_x,
    input  logic [sgoc_pkg::CoordW-1:0]   i_end_y,
    input  logic                          i_cfg_we,
    input  logic [sgoc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [sgoc_pkg::SizeW-1:0]    i_cfg_data,
    output logic [sgoc_pkg::CountW-1:0]   o_overlap_cells,
    output logic [sgoc_pkg::StatusW-1:0]  o_segment_status
);
    import sgoc_pkg::*;

    localparam int CellW = $clog2(GRID_DIM);
    localparam int AddrW = 2 * CellW;
    localparam int Depth = 1 << AddrW;
    localparam int DimW  = $clog2(GRID_DIM + 1);
    localparam int CmpW  = (DimW > SizeW) ? DimW : SizeW;

    logic              r_diag;
    logic [SizeW-1:0]  r_cols;
    logic [SizeW-1:0]  r_rows;
    logic [CoordW-1:0] r_x;
    logic [CoordW-1:0] r_y;
    logic [CoordW-1:0] r_x1;
    logic [CoordW-1:0] r_y1;
    logic [CoordW-1:0] r_rem;
    t_seg_status       r_status;
    logic [CountW-1:0] r_total;
    logic              r_wb_valid;
    logic [AddrW-1:0]  r_wb_addr;
    logic [AddrW-1:0]  r_clr_addr;

    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [CoordW-1:0] seg_len;
    logic              off_grid;
    t_seg_status       chk_status;
    logic [AddrW-1:0]  cur_addr;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    logic [HitW-1:0]   wr_data;
    logic [HitW-1:0]   rd_data;

    // endpoint outside min(lim, GRID_DIM)
    function automatic logic beyond(input logic [CoordW-1:0] c,
                                    input logic [SizeW-1:0]  lim);
        return (CmpW'(c) >= CmpW'(lim)) || (CmpW'(c) >= CmpW'(GRID_DIM));
    endfunction

    function automatic logic [CoordW-1:0] step_to(input logic [CoordW-1:0] c,
                                                  input logic [CoordW-1:0] tgt);
        if (tgt > c) begin
            return c + 1'b1;
        end else if (tgt < c) begin
            return c - 1'b1;
        end
        return c;
    endfunction

    // classification
    always_comb begin
        dx       = (r_x > r_x1) ? (r_x - r_x1) : (r_x1 - r_x);
        dy       = (r_y > r_y1) ? (r_y - r_y1) : (r_y1 - r_y);
        seg_len  = (dy > dx) ? dy : dx;
        off_grid = beyond(r_x, r_cols) || beyond(r_x1, r_cols) ||
                   beyond(r_y, r_rows) || beyond(r_y1, r_rows);
        if (off_grid) begin
            chk_status = ST_OUT_OF_GRID;
        end else if (dx == '0 || dy == '0) begin
            chk_status = ST_DRAWN;
        end else if (dx == dy) begin
            chk_status = r_diag ? ST_DRAWN : ST_DIAG_OFF;
        end else begin
            chk_status = ST_SLANTED;
        end
    end

    assign cur_addr = {CellW'(r_y), CellW'(r_x)};

    // write port: clear sweep or write-back of the cell read last cycle
    always_comb begin
        if (i_cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_wb_valid && (rd_data < HitSat);
            wr_addr = r_wb_addr;
            wr_data = rd_data + 1'b1;
        end
    end

    sgoc_ram #(
        .WIDTH (HitW),
        .DEPTH (Depth)
    ) u_hits (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (cur_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag     <= 1'b0;
            r_cols     <= SizeReset;
            r_rows     <= SizeReset;
            r_total    <= '0;
            r_wb_valid <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DIAG: r_diag <= i_cfg_data[0];
                    CFG_COLS: r_cols <= i_cfg_data;
                    CFG_ROWS: r_rows <= i_cfg_data;
                    default:  ;
                endcase
            end
            r_wb_valid <= i_cmd.draw;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // cell goes 1 -> 2: new overlap
            if (r_wb_valid && rd_data == HitSat - 1'b1 && r_total != CountMax) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= cur_addr;
        if (i_cmd.load) begin
            r_x  <= i_start_x;
            r_y  <= i_start_y;
            r_x1 <= i_end_x;
            r_y1 <= i_end_y;
        end else if (i_cmd.draw) begin
            r_x   <= step_to(r_x, r_x1);
            r_y   <= step_to(r_y, r_y1);
            r_rem <= r_rem - 1'b1;
        end
        if (i_cmd.check) begin
            r_status <= chk_status;
            r_rem    <= seg_len;
        end
    end

    assign o_stat.drawable   = (chk_status == ST_DRAWN);
    assign o_stat.last_cell  = (r_rem == '0);
    assign o_stat.clear_last = &r_clr_addr;

    assign o_overlap_cells  = r_total;
    assign o_segment_status = r_status;

endmodule

// ===== tb/tb_segment_grid_overlap_counter.sv =====
// Testbench for segment_grid_overlap_counter: feeds directed and random segments with
// register writes between phases, predicts count and status per item, checks each result.
// Depends on sgoc_pkg and the RTL of the block; needs no files or arguments.
module tb_segment_grid_overlap_counter;
    import sgoc_pkg::*;

    localparam int GridDim       = GridDimDefault;
    // slowest quiet stretch is the store clear after reset
    localparam int WatchdogLimit = 4 * GridDim * GridDim;
    localparam int DrainCycles   = GridDim + 8;
    localparam int RandomPhases  = 8;
    localparam int ItemsPerPhase = 70;
    localparam int SizeMax       = (1 << SizeW) - 1;
    localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

    // one entry of the stimulus queue: a register write or a segment item
    typedef struct {
        bit                 is_reg;
        logic [CfgIdxW-1:0] reg_idx;
        logic [SizeW-1:0]   reg_data;
        logic [CoordW-1:0]  x0;
        logic [CoordW-1:0]  y0;
        logic [CoordW-1:0]  x1;
        logic [CoordW-1:0]  y1;
    } t_work;

    typedef struct {
        logic [CountW-1:0] cells;
        t_seg_status       status;
    } t_seg_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [CoordW-1:0]   i_start_x   = '0;
    logic [CoordW-1:0]   i_start_y   = '0;
    logic [CoordW-1:0]   i_end_x     = '0;
    logic [CoordW-1:0]   i_end_y     = '0;
    logic                o_strobe;
    logic [CountW-1:0]   o_overlap_cells;
    logic [StatusW-1:0]  o_segment_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [SizeW-1:0]    i_cfg_data  = '0;

    // predicted state of the block
    bit   [HitW-1:0]     hit_store [GridDim*GridDim];
    logic [CountW-1:0]   overlap_total = '0;
    logic                diag_on       = 1'b0;
    logic [SizeW-1:0]    cols_reg      = SizeReset;
    logic [SizeW-1:0]    rows_reg      = SizeReset;

    t_work               work_q[$];
    t_seg_result         counts_due[$];
    t_seg_result         due_now;
    t_work               cur_work;
    bit                  holding     = 1'b0;
    int                  gap_left    = 0;
    int                  burst_left  = 0;
    int                  n_sent      = 0;
    int                  n_checked   = 0;
    int                  n_errors    = 0;
    int                  idle_cycles = 0;

    segment_grid_overlap_counter #(
        .GRID_DIM(GridDim)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .o_strobe         (o_strobe),
        .o_overlap_cells  (o_overlap_cells),
        .o_segment_status (o_segment_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] data);
        case (idx)
            CFG_DIAG: diag_on  = data[0];
            CFG_COLS: cols_reg = data;
            CFG_ROWS: rows_reg = data;
            default:  ;   // unused index: write dropped
        endcase
    endfunction

    // Classify one segment against the current grid, draw it if allowed, and
    // return the running count of cells hit twice or more plus the status.
    function automatic t_seg_result draw_and_count(t_work w);
        int          cols, rows, x, y, dx, dy, steps, i, idx;
        t_seg_result r;
        cols = (cols_reg > SizeW'(GridDim)) ? GridDim : int'(cols_reg);
        rows = (rows_reg > SizeW'(GridDim)) ? GridDim : int'(rows_reg);
        x    = int'(w.x0);
        y    = int'(w.y0);
        dx   = int'(w.x1) - x;
        dy   = int'(w.y1) - y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        // grid bounds are checked ahead of the shape
        if (x >= cols || int'(w.x1) >= cols || y >= rows || int'(w.y1) >= rows)
            r.status = ST_OUT_OF_GRID;
        else if (dx == 0 || dy == 0)
            r.status = ST_DRAWN;
        else if (dx == dy)
            r.status = diag_on ? ST_DRAWN : ST_DIAG_OFF;
        else
            r.status = ST_SLANTED;
        if (r.status == ST_DRAWN) begin
            steps = (dx > dy) ? dx : dy;
            for (i = 0; i <= steps; i++) begin
                idx = y * GridDim + x;
                // hits saturate at two; the count moves only on the second hit
                if (hit_store[idx] < HitSat) begin
                    hit_store[idx] = hit_store[idx] + 1'b1;
                    if (hit_store[idx] == HitSat && overlap_total != CountMax)
                        overlap_total = overlap_total + 1'b1;
                end
                if (int'(w.x1) > x) x++;
                else if (int'(w.x1) < x) x--;
                if (int'(w.y1) > y) y++;
                else if (int'(w.y1) < y) y--;
            end
        end
        r.cells = overlap_total;
        return r;
    endfunction

    function automatic void queue_segment(int x0, int y0, int x1, int y1);
        t_work w;
        w          = '{default: '0};
        w.x0       = CoordW'(x0);
        w.y0       = CoordW'(y0);
        w.x1       = CoordW'(x1);
        w.y1       = CoordW'(y1);
        work_q     = {work_q, w};
    endfunction

    function automatic void queue_register(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] data);
        t_work w;
        w          = '{default: '0};
        w.is_reg   = 1'b1;
        w.reg_idx  = idx;
        w.reg_data = data;
        work_q     = {work_q, w};
    endfunction

    function automatic int clip(int v, int n);
        if (v < 0)
            return 0;
        return (v > n - 1) ? n - 1 : v;
    endfunction

    // grid sizes: mostly small so that overlaps are dense, some full and saturating
    function automatic logic [SizeW-1:0] pick_grid_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SizeW'($urandom_range(2, 48));
            5:             return SizeW'($urandom_range(49, GridDim - 1));
            6:             return SizeW'(GridDim);
            7:             return SizeW'($urandom_range(GridDim + 1, SizeMax));
            8:             return SizeW'(1);
            default:       return SizeW'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        n_errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Driver: presents the head of the work queue. Register writes wait until
    // every segment sent so far has reported and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holding     = 1'b0;
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (holding && !cur_work.is_reg && start && !busy) begin
                counts_due = {counts_due, draw_and_count(cur_work)};
                n_sent++;
                holding = 1'b0;
                // gap before the next item: mostly none or short, a few long,
                // with occasional bursts of back-to-back items
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else begin
                    case ($urandom_range(0, 19))
                        0:                   burst_left = $urandom_range(10, 40);
                        1, 2, 3, 4, 5, 6, 7: gap_left = 0;
                        8, 9, 10, 11, 12:    gap_left = $urandom_range(1, 3);
                        13, 14, 15, 16:      gap_left = $urandom_range(4, 12);
                        default:             gap_left = $urandom_range(20, 80);
                    endcase
                end
            end else if (holding && cur_work.is_reg && i_cfg_valid && o_cfg_ready) begin
                apply_register(cur_work.reg_idx, cur_work.reg_data);
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0)
                    gap_left--;
                else if (work_q.size() != 0 &&
                         (!work_q[0].is_reg || (n_checked == n_sent && !busy))) begin
                    cur_work = work_q.pop_front();
                    holding  = 1'b1;
                end
            end
            start       <= holding && !cur_work.is_reg;
            i_cfg_valid <= holding && cur_work.is_reg;
            // lines of the channel not in use carry noise
            if (holding && !cur_work.is_reg) begin
                i_start_x <= cur_work.x0;
                i_start_y <= cur_work.y0;
                i_end_x   <= cur_work.x1;
                i_end_y   <= cur_work.y1;
            end else begin
                i_start_x <= CoordW'($urandom);
                i_start_y <= CoordW'($urandom);
                i_end_x   <= CoordW'($urandom);
                i_end_y   <= CoordW'($urandom);
            end
            if (holding && cur_work.is_reg) begin
                i_cfg_index <= cur_work.reg_idx;
                i_cfg_data  <= cur_work.reg_data;
            end else begin
                i_cfg_index <= CfgIdxW'($urandom);
                i_cfg_data  <= SizeW'($urandom);
            end
        end
    end

    // Monitor: each strobe is one result, checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (counts_due.size() == 0) begin
                flag_mismatch($sformatf("result with no item pending: cells %0d status %0d",
                                        o_overlap_cells, o_segment_status));
            end else begin
                due_now = counts_due.pop_front();
                n_checked <= n_checked + 1;
                if (o_overlap_cells !== due_now.cells)
                    flag_mismatch($sformatf("item %0d: overlap_cells %0d, expected %0d",
                                            n_checked, o_overlap_cells, due_now.cells));
                if (o_segment_status !== due_now.status)
                    flag_mismatch($sformatf("item %0d: segment_status %0d, expected %0d",
                                            n_checked, o_segment_status, due_now.status));
            end
        end
    end

    // Watchdog: cycles without any handshake or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int               phase, n, kind, len, sx, sy, x0, y0;
        int               cols_eff, rows_eff, win_x, win_y, ox, oy, room_x, room_y;
        logic [SizeW-1:0] cols_w, rows_w;

        // ---- directed part, reset settings: diag off, full grid ----
        queue_register(CfgIdxUnused, '0);          // must not shrink the grid
        queue_segment(0, 0, 0, 0);                 // single cell
        queue_segment(0, 0, GridDim - 1, 0);       // full row, crosses the single cell
        queue_segment(GridDim - 1, GridDim - 1, GridDim - 1, 0);  // full column, upward
        queue_segment(0, 0, 0, 0);                 // third hit saturates
        queue_segment(GridDim - 1, GridDim - 1, GridDim - 1, GridDim - 1);
        queue_segment(0, 1, 5, 6);                 // diagonal while diag is off
        queue_segment(0, 0, 3, 7);                 // neither straight nor diagonal
        queue_segment(GridDim - 1, 0, 0, GridDim - 1);
        // diag on with upper data bits set; columns above the grid saturate
        queue_register(CFG_DIAG, SizeW'(SizeMax));
        queue_register(CFG_COLS, SizeW'(SizeMax));
        queue_register(CFG_ROWS, SizeW'(GridDim));
        queue_segment(0, 0, GridDim - 1, GridDim - 1);
        queue_segment(GridDim - 1, 0, 0, GridDim - 1);
        queue_segment(10, 5, 5, 10);
        queue_segment(2, 9, 7, 0);
        // one-cell grid
        queue_register(CFG_COLS, SizeW'(1));
        queue_register(CFG_ROWS, SizeW'(1));
        queue_segment(0, 0, 0, 0);
        queue_segment(1, 0, 1, 0);
        queue_segment(0, 0, 0, 1);
        // zero columns: everything is outside
        queue_register(CFG_COLS, '0);
        queue_segment(0, 0, 0, 0);
        // resize keeps old hits; bounds come before shape
        queue_register(CFG_COLS, SizeW'(5));
        queue_register(CFG_ROWS, SizeW'(7));
        queue_segment(4, 6, 4, 0);
        queue_segment(5, 0, 5, 0);
        queue_segment(0, 7, 0, 7);
        queue_segment(0, 0, 9, 2);
        queue_segment(0, 0, 4, 4);
        queue_register(CFG_DIAG, SizeW'(2));       // bit 0 clear: diag off
        queue_segment(4, 0, 0, 4);

        // ---- random phases: new settings, then mostly short segments in a window ----
        for (phase = 0; phase < RandomPhases; phase++) begin
            cols_w = pick_grid_size();
            rows_w = pick_grid_size();
            queue_register(CFG_DIAG, SizeW'($urandom));
            queue_register(CFG_COLS, cols_w);
            queue_register(CFG_ROWS, rows_w);
            if ($urandom_range(0, 3) == 0)
                queue_register(CfgIdxUnused, SizeW'($urandom));
            cols_eff = (cols_w > SizeW'(GridDim)) ? GridDim : int'(cols_w);
            rows_eff = (rows_w > SizeW'(GridDim)) ? GridDim : int'(rows_w);
            // a small window keeps overlaps frequent on large grids
            win_x = (cols_eff < 40) ? cols_eff : 40;
            win_y = (rows_eff < 40) ? rows_eff : 40;
            ox    = $urandom_range(0, cols_eff - win_x);
            oy    = $urandom_range(0, rows_eff - win_y);
            for (n = 0; n < ItemsPerPhase; n++) begin
                x0   = ox + $urandom_range(0, win_x - 1);
                y0   = oy + $urandom_range(0, win_y - 1);
                len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, GridDim - 1)
                                                     : $urandom_range(0, 12);
                sx   = ($urandom_range(0, 1) == 1) ? 1 : -1;
                sy   = ($urandom_range(0, 1) == 1) ? 1 : -1;
                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    // anywhere in the coordinate range: mostly out of grid
                    queue_segment($urandom_range(0, GridDim - 1), $urandom_range(0, GridDim - 1),
                                  $urandom_range(0, GridDim - 1), $urandom_range(0, GridDim - 1));
                end else if (kind < 45) begin
                    queue_segment(x0, y0, clip(x0 + sx * len, cols_eff), y0);
                end else if (kind < 80) begin
                    queue_segment(x0, y0, x0, clip(y0 + sy * len, rows_eff));
                end else if (kind < 94) begin
                    room_x = (sx > 0) ? cols_eff - 1 - x0 : x0;
                    room_y = (sy > 0) ? rows_eff - 1 - y0 : y0;
                    if (len > room_x) len = room_x;
                    if (len > room_y) len = room_y;
                    queue_segment(x0, y0, x0 + sx * len, y0 + sy * len);
                end else begin
                    queue_segment(x0, y0, ox + $urandom_range(0, win_x - 1),
                                  oy + $urandom_range(0, win_y - 1));
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (work_q.size() != 0 || holding || counts_due.size() != 0)
            @(posedge i_clk);
        // catch stray strobes after the last result
        repeat (DrainCycles) @(posedge i_clk);

        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
